>>> rtl/double_ended_queue_unit_defines.svh
// Assertion macros shared by the checker of the double-ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dq_pkg.sv
// Types and codes of the double-ended queue unit.
`default_nettype none

package dq_pkg;

  // Field widths fixed by the word formats.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;

  // Command word.
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] push_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] pop_value;
    logic [STAT_W-1:0]         status;
    logic [FILL_W-1:0]         fill_count;
    logic                      is_empty;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/dq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: ring pointers, command decode and RAM.
//
//   channel  ports                    handshake
//   -------  -----------------------  ---------------------------------------
//   command  start, busy, in_word     word taken at an edge with start && !busy
//   result   out_strobe, out_word     word valid in each cycle that out_strobe is high
//
// A new command may be accepted at every edge, so busy stays low. Each result appears
// in the cycle after its command, as the read port of the entry RAM is registered.
// State updates at the accept edge, so the next command already sees the new front
// index and count. rst_n (synchronous, active low) empties the queue; the entry RAM
// is not cleared. The receiver cannot stall the result side.
`default_nettype none

module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire dq_pkg::in_word_t in_word,
  output logic                  out_strobe,
  output dq_pkg::out_word_t     out_word
);

  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  logic [AW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_strobe_r;
  logic               pop_ok_r, pop_ok_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;

  logic               accept;
  logic               full, empty;
  logic [AW-1:0]      front_dec, front_inc;
  logic [SW-1:0]      tail_sum, last_sum;
  logic [AW-1:0]      tail_pos, last_pos;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == FULL_CNT);
  assign empty  = (count_r == '0);

  // Ring positions next to the front, wrapping modulo the depth.
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);

  // Position after the back entry and of the back entry itself.
  // Both sums stay below twice the depth, so one subtract wraps them.
  assign tail_sum = SW'(front_r) + SW'(count_r);
  assign last_sum = tail_sum - SW'(1);
  assign tail_pos = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign last_pos = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

  // Command decode: pointer update and RAM access.
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    pop_ok_nxt = 1'b0;
    status_nxt = ST_OK;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = tail_pos;
    ram_raddr  = front_r;
    if (accept) begin
      case (in_word.cmd)
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_OVER;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_OVER;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_pos;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = front_r;
            pop_ok_nxt = 1'b1;
            front_nxt  = front_inc;
            count_nxt  = count_r - CW'(1);
          end
        end
        default: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = last_pos;
            pop_ok_nxt = 1'b1;
            count_nxt  = count_r - CW'(1);
          end
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r      <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
      pop_ok_r     <= 1'b0;
    end else begin
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= accept;
      pop_ok_r     <= pop_ok_nxt;
    end
  end

  // Result status register.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  dq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word.push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result word: the count registers already hold the state after the command.
  assign out_strobe          = out_strobe_r;
  assign out_word.pop_value  = pop_ok_r ? ram_rdata : '0;
  assign out_word.status     = status_r;
  assign out_word.fill_count = FILL_W'(count_r);
  assign out_word.is_empty   = (count_r == '0);

endmodule

`default_nettype wire

>>> rtl/dq_checker.sv
// Port-level checker of the double-ended queue unit and its bind statement.
`default_nettype none

`include "double_ended_queue_unit_defines.svh"

module dq_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire dq_pkg::in_word_t  in_word,
  input wire logic              out_strobe,
  input wire dq_pkg::out_word_t out_word
);

  import dq_pkg::*;

  logic [CMD_W-1:0] cmd_r;
  logic             prev_push;
  logic             zero_due;
  logic             fail_seen;
  logic             under_seen;

  // Command of the word whose result is on the ports in this cycle.
  always_ff @(posedge clk) begin
    cmd_r <= in_word.cmd;
  end

  // Conditions that the assertions below look at.
  assign prev_push  = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_PUSH_BACK);
  assign zero_due   = out_strobe && (prev_push || (out_word.status != ST_OK));
  assign fail_seen  = out_strobe && (out_word.status != ST_OK);
  assign under_seen = (out_word.status == ST_UNDER);

  // Every accepted word yields a result in the next cycle.
  `DQ_ASSERT_NXT(a_result_follows, start && !busy, out_strobe, "result word missing")

  // No result appears without a word accepted in the cycle before.
  `DQ_ASSERT_IMP(a_no_spurious, out_strobe, $past(start && !busy), "spurious result word")

  // A push or a failed pop returns a zero value.
  `DQ_ASSERT_IMP(a_zero_value, zero_due, out_word.pop_value == '0, "value not zero")

  // Underflow leaves the queue empty, overflow leaves it non-empty.
  `DQ_ASSERT_IMP(a_flag_status, fail_seen, out_word.is_empty == under_seen, "empty flag mismatch")

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_word    (in_word),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

`default_nettype wire
